// ===== hdl/tst_pkg.sv =====
package tst_pkg;

    // table geometry: two adjacent slots share one memory row
    localparam int INDEX_BITS = 16;
    localparam int ROW_BITS   = INDEX_BITS - 1;
    localparam int ROW_COUNT  = 2 ** ROW_BITS;

    // operation codes
    localparam logic [1:0] OP_PROBE = 2'd0;
    localparam logic [1:0] OP_STORE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // replacement margins
    localparam logic [3:0] SAME_KEY_MARGIN  = 4'd2;
    localparam logic [3:0] OTHER_KEY_MARGIN = 4'd4;
    localparam logic [3:0] EXACT_BONUS      = 4'd2;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_TRANSFORM_LOW  = 3'd0,
        CFG_TRANSFORM_HIGH = 3'd1,
        CFG_EXACT_MASK     = 3'd2,
        CFG_MISS_MOVE      = 3'd3,
        CFG_MISS_EVAL      = 3'd4,
        CFG_MISS_DRAFT     = 3'd5,
        CFG_MISS_FLAGS     = 3'd6
    } cfg_idx_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR
    } state_t;

    // one slot, draft held apart in its own memory
    typedef struct packed {
        logic [31:0] key2;
        logic [31:0] eval;
        logic [7:0]  move_a;
        logic [7:0]  move_b;
        logic [7:0]  move_c;
        logic [7:0]  move_d;
        logic [7:0]  key1;
        logic [7:0]  sel;
        logic [7:0]  flags;
    } slot_t;

    // request held between accept and execute
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  code1_top;
        logic [31:0] code2;
        logic        slot_bit;
        logic [31:0] score;
        logic [7:0]  move_a;
        logic [7:0]  move_b;
        logic [7:0]  move_c;
        logic [7:0]  move_d;
        logic [7:0]  flags;
        logic [7:0]  depth;
        logic [7:0]  sel;
    } req_t;

    // miss values and replacement setup
    typedef struct packed {
        logic [7:0]  exact_mask;
        logic [7:0]  miss_move;
        logic [31:0] miss_eval;
        logic [7:0]  miss_draft;
        logic [7:0]  miss_flags;
    } miss_cfg_t;

    // one result beat
    typedef struct packed {
        logic        found;
        logic        written;
        logic [31:0] eval;
        logic [7:0]  move_a;
        logic [7:0]  move_b;
        logic [7:0]  move_c;
        logic [7:0]  move_d;
        logic [7:0]  flags;
        logic [7:0]  draft;
        logic [7:0]  sel;
    } result_t;

endpackage

// ===== hdl/tst_engine.sv =====
module tst_engine (
    input  tst_pkg::req_t            req,
    input  tst_pkg::miss_cfg_t       cfg,
    input  tst_pkg::slot_t [1:0]     row_slots,
    input  logic [1:0][7:0]          row_drafts,
    output tst_pkg::result_t         result,
    output logic                     wr_en,
    output tst_pkg::slot_t [1:0]     new_slots,
    output logic [1:0][7:0]          new_drafts
);

    logic            sel_a;
    logic            sel_b;
    logic            hit_a;
    logic            hit_b;
    logic            chosen;
    logic [3:0]      margin;
    logic            store_ok;
    tst_pkg::slot_t  new_slot;
    tst_pkg::slot_t  pick_slot;
    logic [7:0]      pick_draft;

    // slot compare and replacement choice
    always_comb begin
        sel_a = req.slot_bit;
        sel_b = ~req.slot_bit;
        hit_a = (row_slots[sel_a].key2 == req.code2) && (row_slots[sel_a].key1 == req.code1_top);
        hit_b = (row_slots[sel_b].key2 == req.code2) && (row_slots[sel_b].key1 == req.code1_top);

        if (hit_a) begin
            chosen = sel_a;
        end else if (hit_b) begin
            chosen = sel_b;
        end else if (row_drafts[sel_a] <= row_drafts[sel_b]) begin
            chosen = sel_a;
        end else begin
            chosen = sel_b;
        end

        // deeper old entries survive unless within the margin
        margin = (row_slots[chosen].key2 == req.code2) ? tst_pkg::SAME_KEY_MARGIN
                                                        : tst_pkg::OTHER_KEY_MARGIN;
        if ((req.flags & cfg.exact_mask) != 8'd0) begin
            margin = margin + tst_pkg::EXACT_BONUS;
        end
        store_ok = {1'b0, row_drafts[chosen]} <= ({1'b0, req.depth} + {5'd0, margin});

        new_slot.key2   = req.code2;
        new_slot.eval   = req.score;
        new_slot.move_a = req.move_a;
        new_slot.move_b = req.move_b;
        new_slot.move_c = req.move_c;
        new_slot.move_d = req.move_d;
        new_slot.key1   = req.code1_top;
        new_slot.sel    = req.sel;
        new_slot.flags  = req.flags;
    end

    // write-back row and result
    always_comb begin
        new_slots          = row_slots;
        new_drafts         = row_drafts;
        new_slots[chosen]  = new_slot;
        new_drafts[chosen] = req.depth;
        wr_en              = 1'b0;
        result             = '0;
        pick_slot          = row_slots[sel_a];
        pick_draft         = row_drafts[sel_a];

        case (req.op)
            tst_pkg::OP_PROBE: begin
                if (hit_a || hit_b) begin
                    if (!hit_a) begin
                        pick_slot  = row_slots[sel_b];
                        pick_draft = row_drafts[sel_b];
                    end
                    result.found  = 1'b1;
                    result.eval   = pick_slot.eval;
                    result.move_a = pick_slot.move_a;
                    result.move_b = pick_slot.move_b;
                    result.move_c = pick_slot.move_c;
                    result.move_d = pick_slot.move_d;
                    result.flags  = pick_slot.flags;
                    result.draft  = pick_draft;
                    result.sel    = pick_slot.sel;
                end else begin
                    result.eval   = cfg.miss_eval;
                    result.move_a = cfg.miss_move;
                    result.move_b = cfg.miss_move;
                    result.move_c = cfg.miss_move;
                    result.move_d = cfg.miss_move;
                    result.flags  = cfg.miss_flags;
                    result.draft  = cfg.miss_draft;
                end
            end
            tst_pkg::OP_STORE: begin
                wr_en = store_ok;
                if (store_ok) begin
                    pick_slot  = new_slot;
                    pick_draft = req.depth;
                end else begin
                    pick_slot  = row_slots[chosen];
                    pick_draft = row_drafts[chosen];
                end
                result.found   = hit_a || hit_b;
                result.written = store_ok;
                result.eval    = pick_slot.eval;
                result.move_a  = pick_slot.move_a;
                result.move_b  = pick_slot.move_b;
                result.move_c  = pick_slot.move_c;
                result.move_d  = pick_slot.move_d;
                result.flags   = pick_slot.flags;
                result.draft   = pick_draft;
                result.sel     = pick_slot.sel;
            end
            default: begin
                result = '0;
            end
        endcase
    end

endmodule

// ===== hdl/two_slot_transposition_table_top.sv =====
// Two-way transposition table with depth-preferred replacement.
// Input beats arrive on s_tvalid/s_tready/s_tdata with the operation code in
// s_tuser (probe, store, clear all drafts); one result beat per item leaves
// on m_tvalid/m_tready/m_tdata with found and written in m_tuser.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_wdata.
// Both slots of an item share one row of the slot memory, so each probe or store
// costs a single read and at most one write: the row is read in the accept cycle,
// compared and written back in execute once the output register is free, and the
// result is registered then. A clear sweeps the draft memory one row a cycle.
// After aresetn both memories are swept to zero, one row a cycle; s_tready stays low
// meanwhile, configuration writes are taken. A result beat waits in its output
// register while m_tready is low; the next item is still accepted and then holds
// in execute until the register frees.
module two_slot_transposition_table_top (
    input  logic         aclk,
    input  logic         aresetn,
    // input channel
    input  logic         s_tvalid,
    output logic         s_tready,
    // hash_low[31:0] hash_high[63:32] swap_halves[64] score[96:65]
    // move_a[104:97] move_b[112:105] move_c[120:113] move_d[128:121]
    // bound_flags[136:129] depth[144:137] selectiveness[152:145], zero fill
    input  logic [159:0] s_tdata,
    // op[1:0]
    input  logic [1:0]   s_tuser,
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    // entry_eval[31:0] entry_move_a[39:32] entry_move_b[47:40]
    // entry_move_c[55:48] entry_move_d[63:56] entry_flags[71:64]
    // entry_draft[79:72] entry_selectivity[87:80]
    output logic [87:0]  m_tdata,
    // found[0] written[1]
    output logic [1:0]   m_tuser,
    // configuration
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    tst_pkg::state_t             state_reg, state_next;
    logic [tst_pkg::ROW_BITS-1:0] sweep_reg, sweep_next;

    logic [31:0] xf_low_reg;
    logic [31:0] xf_high_reg;
    logic [7:0]  exact_mask_reg;
    logic [7:0]  miss_move_reg;
    logic [31:0] miss_eval_reg;
    logic [7:0]  miss_draft_reg;
    logic [7:0]  miss_flags_reg;

    tst_pkg::req_t                req_reg;
    logic [tst_pkg::ROW_BITS-1:0] row_addr_reg;

    tst_pkg::slot_t [1:0] row_mem [tst_pkg::ROW_COUNT];
    logic [1:0][7:0]      draft_mem [tst_pkg::ROW_COUNT];
    tst_pkg::slot_t [1:0] row_rd_reg;
    logic [1:0][7:0]      draft_rd_reg;

    logic        m_tvalid_reg;
    logic [87:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    logic [31:0] h_lo;
    logic [31:0] h_hi;
    logic [31:0] code1;
    logic [31:0] code2;
    logic        accept;
    logic        ready_c;
    logic        exec_fire;

    logic                         row_wr_en;
    logic                         draft_wr_en;
    logic [tst_pkg::ROW_BITS-1:0] wr_addr;
    tst_pkg::slot_t [1:0]         row_wr_data;
    logic [1:0][7:0]              draft_wr_data;

    tst_pkg::miss_cfg_t   miss_cfg;
    tst_pkg::result_t     eng_result;
    logic                 eng_wr_en;
    tst_pkg::slot_t [1:0] eng_slots;
    logic [1:0][7:0]      eng_drafts;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xf_low_reg     <= '0;
            xf_high_reg    <= '0;
            exact_mask_reg <= 8'd1;
            miss_move_reg  <= '0;
            miss_eval_reg  <= '0;
            miss_draft_reg <= '0;
            miss_flags_reg <= '0;
        end else if (cfg_wr_en) begin
            case (tst_pkg::cfg_idx_t'(cfg_index))
                tst_pkg::CFG_TRANSFORM_LOW:  xf_low_reg     <= cfg_wdata;
                tst_pkg::CFG_TRANSFORM_HIGH: xf_high_reg    <= cfg_wdata;
                tst_pkg::CFG_EXACT_MASK:     exact_mask_reg <= cfg_wdata[7:0];
                tst_pkg::CFG_MISS_MOVE:      miss_move_reg  <= cfg_wdata[7:0];
                tst_pkg::CFG_MISS_EVAL:      miss_eval_reg  <= cfg_wdata;
                tst_pkg::CFG_MISS_DRAFT:     miss_draft_reg <= cfg_wdata[7:0];
                tst_pkg::CFG_MISS_FLAGS:     miss_flags_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // hash transform and slot address
    always_comb begin
        h_lo  = s_tdata[31:0] ^ xf_low_reg;
        h_hi  = s_tdata[63:32] ^ xf_high_reg;
        code1 = s_tdata[64] ? h_hi : h_lo;
        code2 = s_tdata[64] ? h_lo : h_hi;
    end

    assign s_tready = ready_c;
    assign accept   = s_tvalid && ready_c;

    // request capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg.op        <= s_tuser;
            req_reg.code1_top <= code1[31:24];
            req_reg.code2     <= code2;
            req_reg.slot_bit  <= code1[0];
            req_reg.score     <= s_tdata[96:65];
            req_reg.move_a    <= s_tdata[104:97];
            req_reg.move_b    <= s_tdata[112:105];
            req_reg.move_c    <= s_tdata[120:113];
            req_reg.move_d    <= s_tdata[128:121];
            req_reg.flags     <= s_tdata[136:129];
            req_reg.depth     <= s_tdata[144:137];
            req_reg.sel       <= s_tdata[152:145];
            row_addr_reg      <= code1[tst_pkg::INDEX_BITS-1:1];
        end
    end

    // slot row memory
    always_ff @(posedge aclk) begin
        if (row_wr_en) begin
            row_mem[wr_addr] <= row_wr_data;
        end
        if (accept) begin
            row_rd_reg <= row_mem[code1[tst_pkg::INDEX_BITS-1:1]];
        end
    end

    // draft memory
    always_ff @(posedge aclk) begin
        if (draft_wr_en) begin
            draft_mem[wr_addr] <= draft_wr_data;
        end
        if (accept) begin
            draft_rd_reg <= draft_mem[code1[tst_pkg::INDEX_BITS-1:1]];
        end
    end

    always_comb begin
        miss_cfg.exact_mask = exact_mask_reg;
        miss_cfg.miss_move  = miss_move_reg;
        miss_cfg.miss_eval  = miss_eval_reg;
        miss_cfg.miss_draft = miss_draft_reg;
        miss_cfg.miss_flags = miss_flags_reg;
    end

    tst_engine u_engine (
        .req        (req_reg),
        .cfg        (miss_cfg),
        .row_slots  (row_rd_reg),
        .row_drafts (draft_rd_reg),
        .result     (eng_result),
        .wr_en      (eng_wr_en),
        .new_slots  (eng_slots),
        .new_drafts (eng_drafts)
    );

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tst_pkg::ST_INIT;
            sweep_reg <= '0;
        end else begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
        end
    end

    // next state, memory writes and handshake
    always_comb begin
        state_next    = state_reg;
        sweep_next    = sweep_reg;
        ready_c       = 1'b0;
        exec_fire     = 1'b0;
        row_wr_en     = 1'b0;
        draft_wr_en   = 1'b0;
        wr_addr       = sweep_reg;
        row_wr_data   = '0;
        draft_wr_data = '0;
        case (state_reg)
            tst_pkg::ST_INIT: begin
                row_wr_en   = 1'b1;
                draft_wr_en = 1'b1;
                sweep_next  = sweep_reg + 1'b1;
                if (&sweep_reg) begin
                    state_next = tst_pkg::ST_IDLE;
                end
            end
            tst_pkg::ST_IDLE: begin
                ready_c = 1'b1;
                if (s_tvalid) begin
                    state_next = tst_pkg::ST_EXEC;
                end
            end
            tst_pkg::ST_EXEC: begin
                if (!m_tvalid_reg || m_tready) begin
                    exec_fire     = 1'b1;
                    row_wr_en     = eng_wr_en;
                    draft_wr_en   = eng_wr_en;
                    wr_addr       = row_addr_reg;
                    row_wr_data   = eng_slots;
                    draft_wr_data = eng_drafts;
                    state_next    = (req_reg.op == tst_pkg::OP_CLEAR) ? tst_pkg::ST_CLEAR
                                                                      : tst_pkg::ST_IDLE;
                end
            end
            tst_pkg::ST_CLEAR: begin
                draft_wr_en = 1'b1;
                sweep_next  = sweep_reg + 1'b1;
                if (&sweep_reg) begin
                    state_next = tst_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tst_pkg::ST_INIT;
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (exec_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            m_tdata_reg <= {eng_result.sel, eng_result.draft, eng_result.flags,
                            eng_result.move_d, eng_result.move_c, eng_result.move_b,
                            eng_result.move_a, eng_result.eval};
            m_tuser_reg <= {eng_result.written, eng_result.found};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== hdl/tst_checker.sv =====
module tst_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // memory sweep after reset blocks input
    a_reset_sweep: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready during reset sweep");

    // one item in flight at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is at work");

    // a new result follows an execute cycle
    a_result_after_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without an execute cycle");

endmodule

bind two_slot_transposition_table_top tst_checker u_tst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/tt_lookup_checker.sv =====
module tt_lookup_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    // hash_low, hash_high, swap_halves, score, move_a..move_d,
    // bound_flags, depth, selectiveness, zero fill
    input  logic [159:0] s_tdata,
    // op
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    // entry_eval, entry_move_a..entry_move_d, entry_flags, entry_draft,
    // entry_selectivity
    input  logic [87:0]  m_tdata,
    // found, written
    input  logic [1:0]   m_tuser,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    output int unsigned  fail_count
);

    localparam int SLOT_COUNT = 1 << tst_pkg::INDEX_BITS;

    // shadow of the slot memory: key2, eval, packed moves, key1/sel/flags/draft
    logic [31:0] slot_key2  [SLOT_COUNT];
    logic [31:0] slot_eval  [SLOT_COUNT];
    logic [31:0] slot_moves [SLOT_COUNT];
    logic [31:0] slot_info  [SLOT_COUNT];

    // shadow of the configuration registers
    logic [31:0] reg_xor_low;
    logic [31:0] reg_xor_high;
    logic [7:0]  reg_exact_mask;
    logic [7:0]  reg_miss_move;
    logic [31:0] reg_miss_eval;
    logic [7:0]  reg_miss_draft;
    logic [7:0]  reg_miss_flags;

    tst_pkg::result_t awaited_replies [$];
    int unsigned      mismatches;

    // table starts out all zero
    initial begin
        for (int s = 0; s < SLOT_COUNT; s++) begin
            slot_key2[s]  = '0;
            slot_eval[s]  = '0;
            slot_moves[s] = '0;
            slot_info[s]  = '0;
        end
        mismatches = 0;
    end

    function automatic logic slot_match(input logic [tst_pkg::INDEX_BITS-1:0] idx,
                                        input logic [31:0] code1,
                                        input logic [31:0] code2);
        return (slot_key2[idx] == code2) && (slot_info[idx][31:24] == code1[31:24]);
    endfunction

    function automatic tst_pkg::result_t slot_view(input logic [tst_pkg::INDEX_BITS-1:0] idx);
        tst_pkg::result_t v;
        v        = '0;
        v.eval   = slot_eval[idx];
        v.move_a = slot_moves[idx][7:0];
        v.move_b = slot_moves[idx][15:8];
        v.move_c = slot_moves[idx][23:16];
        v.move_d = slot_moves[idx][31:24];
        v.flags  = slot_info[idx][15:8];
        v.draft  = slot_info[idx][7:0];
        v.sel    = slot_info[idx][23:16];
        return v;
    endfunction

    // applies one request to the shadow table and returns the reply it earns
    function automatic tst_pkg::result_t predict_reply(input logic [1:0] op,
                                                       input logic [159:0] d);
        logic [31:0] half_lo, half_hi, code1, code2;
        logic [7:0]  flags, depth, sel;
        logic [tst_pkg::INDEX_BITS-1:0] i1, i2, idx;
        int unsigned margin;
        logic        full, wrote;
        tst_pkg::result_t r;
        half_lo = d[31:0] ^ reg_xor_low;
        half_hi = d[63:32] ^ reg_xor_high;
        code1   = d[64] ? half_hi : half_lo;
        code2   = d[64] ? half_lo : half_hi;
        flags   = d[136:129];
        depth   = d[144:137];
        sel     = d[152:145];
        i1      = code1[tst_pkg::INDEX_BITS-1:0];
        i2      = {i1[tst_pkg::INDEX_BITS-1:1], ~i1[0]};
        wrote   = 1'b0;
        r       = '0;
        case (op)
            tst_pkg::OP_PROBE: begin
                // first slot wins, second slot checked whenever the first misses
                if (slot_match(i1, code1, code2)) begin
                    r = slot_view(i1);
                    r.found = 1'b1;
                end else if (slot_match(i2, code1, code2)) begin
                    r = slot_view(i2);
                    r.found = 1'b1;
                end else begin
                    r.eval   = reg_miss_eval;
                    r.move_a = reg_miss_move;
                    r.move_b = reg_miss_move;
                    r.move_c = reg_miss_move;
                    r.move_d = reg_miss_move;
                    r.flags  = reg_miss_flags;
                    r.draft  = reg_miss_draft;
                end
            end
            tst_pkg::OP_STORE: begin
                // matching slot, else the shallower one (first slot on a tie)
                full = 1'b1;
                if (slot_match(i1, code1, code2)) begin
                    idx = i1;
                end else if (slot_match(i2, code1, code2)) begin
                    idx = i2;
                end else begin
                    full = 1'b0;
                    idx  = (slot_info[i1][7:0] <= slot_info[i2][7:0]) ? i1 : i2;
                end
                margin = (slot_key2[idx] == code2) ? 32'(tst_pkg::SAME_KEY_MARGIN)
                                                   : 32'(tst_pkg::OTHER_KEY_MARGIN);
                if ((flags & reg_exact_mask) != 8'h00)
                    margin += 32'(tst_pkg::EXACT_BONUS);
                if (32'(slot_info[idx][7:0]) <= 32'(depth) + margin) begin
                    slot_key2[idx]  = code2;
                    slot_eval[idx]  = d[96:65];
                    slot_moves[idx] = d[128:97];
                    slot_info[idx]  = {code1[31:24], sel, flags, depth};
                    wrote = 1'b1;
                end
                r = slot_view(idx);
                r.found   = full;
                r.written = wrote;
            end
            tst_pkg::OP_CLEAR: begin
                for (int s = 0; s < SLOT_COUNT; s++)
                    slot_info[s][7:0] = 8'h00;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t %s: expected %h, got %h", $time, name, want, got);
        end
    endtask

    // follow configuration writes, predict on input beats, compare result beats
    always @(posedge aclk) begin
        tst_pkg::result_t got, want;
        if (!aresetn) begin
            reg_xor_low    = '0;
            reg_xor_high   = '0;
            reg_exact_mask = 8'h01;
            reg_miss_move  = '0;
            reg_miss_eval  = '0;
            reg_miss_draft = '0;
            reg_miss_flags = '0;
            awaited_replies.delete();
            fail_count <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (tst_pkg::cfg_idx_t'(cfg_index))
                    tst_pkg::CFG_TRANSFORM_LOW:  reg_xor_low    = cfg_wdata;
                    tst_pkg::CFG_TRANSFORM_HIGH: reg_xor_high   = cfg_wdata;
                    tst_pkg::CFG_EXACT_MASK:     reg_exact_mask = cfg_wdata[7:0];
                    tst_pkg::CFG_MISS_MOVE:      reg_miss_move  = cfg_wdata[7:0];
                    tst_pkg::CFG_MISS_EVAL:      reg_miss_eval  = cfg_wdata;
                    tst_pkg::CFG_MISS_DRAFT:     reg_miss_draft = cfg_wdata[7:0];
                    tst_pkg::CFG_MISS_FLAGS:     reg_miss_flags = cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                awaited_replies.push_back(predict_reply(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                got         = '0;
                got.found   = m_tuser[0];
                got.written = m_tuser[1];
                got.eval    = m_tdata[31:0];
                got.move_a  = m_tdata[39:32];
                got.move_b  = m_tdata[47:40];
                got.move_c  = m_tdata[55:48];
                got.move_d  = m_tdata[63:56];
                got.flags   = m_tdata[71:64];
                got.draft   = m_tdata[79:72];
                got.sel     = m_tdata[87:80];
                if (awaited_replies.size() == 0) begin
                    mismatches++;
                    $display("%0t unexpected result beat: expected none, got %h",
                             $time, got);
                end else begin
                    want = awaited_replies.pop_front();
                    check_field("found", 32'(want.found), 32'(got.found));
                    check_field("written", 32'(want.written), 32'(got.written));
                    check_field("entry_eval", want.eval, got.eval);
                    check_field("entry_move_a", 32'(want.move_a), 32'(got.move_a));
                    check_field("entry_move_b", 32'(want.move_b), 32'(got.move_b));
                    check_field("entry_move_c", 32'(want.move_c), 32'(got.move_c));
                    check_field("entry_move_d", 32'(want.move_d), 32'(got.move_d));
                    check_field("entry_flags", 32'(want.flags), 32'(got.flags));
                    check_field("entry_draft", 32'(want.draft), 32'(got.draft));
                    check_field("entry_selectivity", 32'(want.sel), 32'(got.sel));
                end
            end
            fail_count <= mismatches + awaited_replies.size();
        end
    end

endmodule

// ===== tb/tb_two_slot_transposition_table_top.sv =====
module tb_two_slot_transposition_table_top;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         IDLE_LIMIT  = 200000;
    localparam int         LONG_HOLD   = 400;
    localparam int         PHASES      = 6;
    localparam int         PHASE_ITEMS = 138;

    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
        logic        rev;
    } tt_position_t;

    typedef struct packed {
        logic [1:0]   op;
        tt_position_t pos;
        logic [31:0]  score;
        logic [31:0]  moves;   // move_d..move_a, move_a lowest
        logic [7:0]   flags;
        logic [7:0]   depth;
        logic [7:0]   sel;
    } tt_request_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata   = '0;
    logic [1:0]   s_tuser   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [87:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_wr_en = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_wdata = '0;
    int unsigned  fail_count;

    int unsigned  beats_in, beats_out, quiet_cycles;
    logic         burst_mode   = 1'b0;
    int           holds_wanted = 0;
    int           holds_done   = 0;
    int           clears_left  = 5;
    logic [31:0]  xor_low_now  = '0;
    logic [31:0]  xor_high_now = '0;
    tt_position_t recent [$];

    two_slot_transposition_table_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    tt_lookup_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count)
    );

    // clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // beat counters and stall watchdog
    always @(posedge aclk) begin
        if (!aresetn) begin
            beats_in     <= 0;
            beats_out    <= 0;
            quiet_cycles <= 0;
        end else begin
            if (s_tvalid && s_tready)
                beats_in <= beats_in + 1;
            if (m_tvalid && m_tready)
                beats_out <= beats_out + 1;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles == IDLE_LIMIT) begin
                $display("tb_two_slot_transposition_table_top: errors");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // result side: random stalls, calm stretches, one long hold-off on request
    initial begin
        int wait_cycles;
        int beat_count;
        logic calm_out;
        beat_count = 0;
        calm_out   = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (beat_count % 30 == 0)
                calm_out = ($urandom_range(0, 3) == 0);
            if (holds_done != holds_wanted) begin
                wait_cycles = LONG_HOLD;
                holds_done++;
            end else begin
                wait_cycles = calm_out ? 0 : $urandom_range(0, 16);
            end
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            beat_count++;
        end
    end

    function automatic tt_request_t make_request(input logic [1:0] op,
                                                 input logic [31:0] lo, hi,
                                                 input logic rev,
                                                 input logic [7:0] flags, depth);
        tt_request_t rq;
        rq.op     = op;
        rq.pos.lo = lo;
        rq.pos.hi = hi;
        rq.pos.rev = rev;
        rq.score  = $urandom();
        rq.moves  = $urandom();
        rq.flags  = flags;
        rq.depth  = depth;
        rq.sel    = 8'($urandom_range(0, 255));
        return rq;
    endfunction

    // mostly revisit recent positions, some as near neighbours or half-matching keys
    function automatic tt_position_t pick_position();
        tt_position_t p;
        int unsigned  r;
        logic [7:0]   tweak;
        r     = $urandom_range(0, 99);
        tweak = 8'($urandom_range(1, 255));
        if (recent.size() > 0 && r < 80) begin
            p = recent[$urandom_range(0, recent.size() - 1)];
            if (r >= 55) begin
                case ($urandom_range(0, 3))
                    0: if (p.rev) p.hi[0] = ~p.hi[0]; else p.lo[0] = ~p.lo[0];
                    1: if (p.rev) p.hi[31:24] ^= tweak; else p.lo[31:24] ^= tweak;
                    2: if (p.rev) p.lo ^= $urandom(); else p.hi ^= $urandom();
                    default: p.rev = ~p.rev;
                endcase
            end
        end else begin
            p.lo  = $urandom();
            p.hi  = $urandom();
            p.rev = 1'($urandom_range(0, 1));
            if (recent.size() >= 24)
                recent.delete($urandom_range(0, recent.size() - 1));
            recent.push_back(p);
        end
        return p;
    endfunction

    function automatic tt_request_t random_request();
        tt_position_t p;
        logic [1:0]   op;
        logic [7:0]   depth;
        int unsigned  r;
        r = $urandom_range(0, 99);
        if (r < 44) begin
            op = tst_pkg::OP_PROBE;
        end else if (r < 96) begin
            op = tst_pkg::OP_STORE;
        end else if (r < 99 || clears_left == 0) begin
            op = OP_UNUSED;
        end else begin
            op = tst_pkg::OP_CLEAR;
            clears_left--;
        end
        depth = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 14));
        p = pick_position();
        return make_request(op, p.lo, p.hi, p.rev, 8'($urandom_range(0, 255)), depth);
    endfunction

    // offer one beat after a random gap, none in burst mode, and hold it until taken
    task automatic send_request(input tt_request_t rq);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {7'd0, rq.sel, rq.depth, rq.flags, rq.moves, rq.score,
                     rq.pos.rev, rq.pos.hi, rq.pos.lo};
        s_tuser  <= rq.op;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // stop offering and wait until every result beat is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (beats_in != beats_out) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input tst_pkg::cfg_idx_t idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // per phase settings: transforms kept, inverted, scrambled or restored
    task automatic configure_phase(input int p);
        logic [31:0] exact;
        case (p)
            1: begin xor_low_now = '1; xor_high_now = '1; end
            4: begin xor_low_now = $urandom(); xor_high_now = $urandom(); end
            5: begin xor_low_now = '0; xor_high_now = '0; end
            default: ;
        endcase
        case (p % 4)
            0: exact = 32'h0000_0000;
            1: exact = 32'h0000_00FF;
            2: exact = $urandom();
            default: exact = 32'h0000_0001;
        endcase
        write_reg(tst_pkg::CFG_TRANSFORM_LOW, xor_low_now);
        write_reg(tst_pkg::CFG_TRANSFORM_HIGH, xor_high_now);
        write_reg(tst_pkg::CFG_EXACT_MASK, exact);
        case (p % 3)
            0: begin
                write_reg(tst_pkg::CFG_MISS_MOVE, 32'h0000_00FF);
                write_reg(tst_pkg::CFG_MISS_EVAL, 32'h7FFF_FFFF);
                write_reg(tst_pkg::CFG_MISS_DRAFT, 32'h0000_00FF);
                write_reg(tst_pkg::CFG_MISS_FLAGS, 32'h0000_00FF);
            end
            1: begin
                write_reg(tst_pkg::CFG_MISS_MOVE, 32'h0000_0000);
                write_reg(tst_pkg::CFG_MISS_EVAL, 32'h8000_0000);
                write_reg(tst_pkg::CFG_MISS_DRAFT, 32'h0000_0000);
                write_reg(tst_pkg::CFG_MISS_FLAGS, 32'h0000_0000);
            end
            default: begin
                write_reg(tst_pkg::CFG_MISS_MOVE, $urandom());
                write_reg(tst_pkg::CFG_MISS_EVAL, $urandom());
                write_reg(tst_pkg::CFG_MISS_DRAFT, $urandom());
                write_reg(tst_pkg::CFG_MISS_FLAGS, $urandom());
            end
        endcase
        cfg_wr_en <= 1'b0;
    endtask

    // main sequence
    initial begin
        tt_request_t rq;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, on reset settings
        // all-zero hash matches an untouched all-zero slot
        send_request(make_request(tst_pkg::OP_PROBE,
                                  32'h0, 32'h0, 1'b0, 8'h00, 8'd0));
        send_request(make_request(tst_pkg::OP_PROBE,
                                  32'h1234_0010, 32'hCAFE_0001, 1'b0, 8'h00, 8'd0));
        // drafts tie, first slot takes it
        rq = make_request(tst_pkg::OP_STORE,
                          32'h1234_0010, 32'hCAFE_0001, 1'b0, 8'h01, 8'd10);
        rq.score = 32'h7FFF_FFFF;
        rq.moves = 32'h0403_0201;
        rq.sel   = 8'd5;
        send_request(rq);
        send_request(make_request(tst_pkg::OP_PROBE,
                                  32'h1234_0010, 32'hCAFE_0001, 1'b0, 8'h00, 8'd0));
        // same index, other key byte: lands in the shallower second slot
        rq = make_request(tst_pkg::OP_STORE,
                          32'h5634_0010, 32'hCAFE_0001, 1'b0, 8'h00, 8'd12);
        rq.score = 32'h8000_0000;
        send_request(rq);
        // first slot misses, second slot hits
        send_request(make_request(tst_pkg::OP_PROBE,
                                  32'h5634_0010, 32'hCAFE_0001, 1'b0, 8'h00, 8'd0));
        // other key, too shallow: skipped, then accepted right at the margin
        send_request(make_request(tst_pkg::OP_STORE,
                                  32'h9934_0011, 32'h0000_BEEF, 1'b0, 8'h00, 8'd0));
        send_request(make_request(tst_pkg::OP_STORE,
                                  32'h9934_0011, 32'h0000_BEEF, 1'b0, 8'h00, 8'd6));
        send_request(make_request(tst_pkg::OP_PROBE,
                                  32'h1234_0010, 32'hCAFE_0001, 1'b0, 8'h00, 8'd0));
        // key2 equal but key byte differs: same-key margin, skip then accept
        send_request(make_request(tst_pkg::OP_STORE,
                                  32'h7734_0010, 32'h0000_BEEF, 1'b0, 8'h00, 8'd3));
        send_request(make_request(tst_pkg::OP_STORE,
                                  32'h7734_0010, 32'h0000_BEEF, 1'b0, 8'h00, 8'd4));
        // exact bonus decides at the boundary
        send_request(make_request(tst_pkg::OP_STORE,
                                  32'h5634_0010, 32'hCAFE_0001, 1'b0, 8'h02, 8'd9));
        send_request(make_request(tst_pkg::OP_STORE,
                                  32'h5634_0010, 32'hCAFE_0001, 1'b0, 8'h03, 8'd8));
        // reverse mode swaps the halves onto the same entry
        send_request(make_request(tst_pkg::OP_PROBE,
                                  32'hCAFE_0001, 32'h5634_0010, 1'b1, 8'h00, 8'd0));
        // field extremes
        rq = make_request(tst_pkg::OP_STORE,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF, 8'hFF);
        rq.score = 32'h8000_0000;
        rq.moves = 32'hFFFF_FFFF;
        rq.sel   = 8'hFF;
        send_request(rq);
        send_request(make_request(tst_pkg::OP_STORE,
                                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 8'h00, 8'd0));
        send_request(make_request(tst_pkg::OP_PROBE,
                                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 8'h00, 8'd0));
        rq = make_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF, 8'hFF);
        rq.score = 32'hFFFF_FFFF;
        send_request(rq);
        // clear drafts, entries survive with draft zero
        send_request(make_request(tst_pkg::OP_CLEAR,
                                  $urandom(), $urandom(), 1'b0, 8'h00, 8'd0));
        send_request(make_request(tst_pkg::OP_PROBE,
                                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'h00, 8'd0));
        send_request(make_request(tst_pkg::OP_STORE,
                                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'h00, 8'd0));
        rq = make_request(tst_pkg::OP_STORE, 32'h0, 32'h0, 1'b0, 8'h00, 8'd0);
        rq.score = '0;
        rq.moves = '0;
        rq.sel   = '0;
        send_request(rq);
        wait_drained();

        // random phases, each under fresh settings
        for (int p = 0; p < PHASES; p++) begin
            configure_phase(p);
            if (p == 3)
                holds_wanted++;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0)
                    burst_mode = (p == 3 && n < 80) ? 1'b1 : ($urandom_range(0, 2) == 0);
                send_request(random_request());
            end
            wait_drained();
        end

        repeat (40) @(posedge aclk);
        if (fail_count == 0)
            $display("tb_two_slot_transposition_table_top: clean");
        else
            $display("tb_two_slot_transposition_table_top: errors");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/tst_pkg.sv
hdl/tst_engine.sv
hdl/two_slot_transposition_table_top.sv
hdl/tst_checker.sv
tb/tt_lookup_checker.sv
tb/tb_two_slot_transposition_table_top.sv
